FILE: rtl/piq_pkg.sv
// Shared types and codes for the positional insert queue.
package piq_pkg;

  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_REMOVE = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [63:0] name;
    logic [63:0] grade;
    logic [15:0] amount;
  } rec_t;

  typedef struct packed {
    action_e     action;
    logic [63:0] record_name;
    logic [63:0] record_grade;
    logic [15:0] record_amount;
    logic [7:0]  position;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [4:0]  occupancy;
    logic        is_empty;
    logic        removed_valid;
    logic [63:0] removed_name;
    logic [63:0] removed_grade;
    logic [15:0] removed_amount;
  } rsp_t;

  // Update command from the control logic to the slot array.
  typedef struct packed {
    logic ins;
    logic rem;
  } op_t;

endpackage

FILE: rtl/positional_insert_queue.sv
// Top level of the positional insert queue: request register, control and result register.
// A request waits in the request register until the result register can take its result.
// Throughput: one request per cycle unless the output stalls; slots all update at once.
// A stalled result holds the request stage, which then stalls the input side.
// Reset (rst_ni low, asynchronous) empties the queue and clears all valid flags.
// Slot contents are not reset; only entries below the count are ever read.
module positional_insert_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  piq_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output piq_pkg::rsp_t out_rsp_o
);
  import piq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  // Common width for comparing the 8-bit position against the count.
  localparam int PW = (CW > 8) ? CW : 8;

  // Request register stage.
  req_t req_q;
  logic req_valid_q;
  // Result register stage.
  rsp_t rsp_q, rsp_d;
  logic out_valid_q;

  op_t           op;
  logic [AW-1:0] at;
  rec_t          rec, head;
  logic [CW-1:0] count, count_after;
  logic          advance, fire, accept, full, empty;
  logic [PW-1:0] pos_w, cnt_w;

  // The result register can take a new result when it is empty or being drained.
  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = req_valid_q && advance;
  assign in_stall_o = req_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (accept) begin
      req_valid_q <= 1'b1;
    end else if (fire) begin
      req_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_req_i;
    end
  end

  assign full  = (count == CW'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign pos_w = PW'(req_q.position);
  assign cnt_w = PW'(count);

  assign rec.name   = req_q.record_name;
  assign rec.grade  = req_q.record_grade;
  assign rec.amount = req_q.record_amount;

  // Decide what the slot array does for the request in the register stage.
  // An insert whose position lies beyond the count becomes an append, and a
  // position of zero is treated as the head, the same as position one.
  always_comb begin
    op     = '0;
    at     = AW'(count);
    rsp_d  = '0;
    rsp_d.status = ST_DONE;
    case (req_q.action)
      ACT_APPEND, ACT_INSERT: begin
        if (full) begin
          rsp_d.status = ST_FULL;
        end else begin
          op.ins = fire;
          if (req_q.action == ACT_INSERT && pos_w <= cnt_w) begin
            at = (req_q.position == 8'd0) ? '0 : AW'(pos_w - PW'(1));
          end
        end
      end
      ACT_REMOVE: begin
        if (empty) begin
          rsp_d.status = ST_EMPTY;
        end else begin
          op.rem               = fire;
          rsp_d.removed_valid  = 1'b1;
          rsp_d.removed_name   = head.name;
          rsp_d.removed_grade  = head.grade;
          rsp_d.removed_amount = head.amount;
        end
      end
      default: begin
        // The unused action code leaves the queue alone and reports done.
      end
    endcase
    count_after = count;
    if (rsp_d.status == ST_DONE && (req_q.action == ACT_APPEND ||
                                    req_q.action == ACT_INSERT)) begin
      count_after = count + CW'(1);
    end else if (rsp_d.removed_valid) begin
      count_after = count - CW'(1);
    end
    rsp_d.occupancy = 5'(count_after);
    rsp_d.is_empty  = (count_after == '0);
  end

  piq_store #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (op),
    .at_i   (at),
    .rec_i  (rec),
    .head_o (head),
    .count_o(count)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

`ifndef ASSERT_OFF
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CW'(QUEUE_DEPTH))
    else $error("entry count exceeds queue depth");

  a_removed_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.removed_valid |-> out_rsp_o.status == ST_DONE)
    else $error("removed record reported with a failing status");

  a_idle_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !op.ins && !op.rem |=> $stable(count))
    else $error("count changed without an insert or remove");

  a_remove_dec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    op.rem |=> count == $past(count) - CW'(1))
    else $error("remove did not lower the count by one");

  a_fire_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_o && out_rsp_o.occupancy == 5'(count))
    else $error("result occupancy disagrees with stored count");
`endif

endmodule

FILE: rtl/piq_store.sv
// Slot array of the positional insert queue with per-slot shift muxes and entry count.
module piq_store #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  piq_pkg::op_t                              op_i,
  input  logic [$clog2(QUEUE_DEPTH)-1:0]            at_i,
  input  piq_pkg::rec_t                             rec_i,
  output piq_pkg::rec_t                             head_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]          count_o
);
  import piq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  rec_t          slot_q [QUEUE_DEPTH];
  logic [CW-1:0] count_q, count_d;

  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_slot
    rec_t slot_d;
    always_comb begin
      slot_d = slot_q[k];
      if (op_i.ins) begin
        if (AW'(k) == at_i) begin
          slot_d = rec_i;
        end else if (AW'(k) > at_i) begin
          if (k > 0) begin
            slot_d = slot_q[(k > 0) ? k - 1 : 0];
          end
        end
      end else if (op_i.rem) begin
        if (k < QUEUE_DEPTH - 1) begin
          slot_d = slot_q[(k < QUEUE_DEPTH - 1) ? k + 1 : k];
        end
      end
    end
    always_ff @(posedge clk_i) begin
      slot_q[k] <= slot_d;
    end
  end

  always_comb begin
    count_d = count_q;
    if (op_i.ins) begin
      count_d = count_q + CW'(1);
    end else if (op_i.rem) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign head_o  = slot_q[0];
  assign count_o = count_q;

endmodule
